// ===== design/tccw_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tccw_pkg
// Shared types and constants of the text console cursor writer.
// ============================================================================
package tccw_pkg;

    localparam int COLUMNS    = 80;
    localparam int STATUS_ROW = 23;

    localparam int ROW_W    = 5;
    localparam int COL_W    = 7;
    localparam int ADDR_W   = 11;
    localparam int PROD_W   = 12;
    localparam int CHAR_W   = 8;
    localparam int COLOUR_W = 8;
    localparam int REQ_W    = 2;
    localparam int OP_W     = 2;
    localparam int ACC_W    = 11;
    localparam int CNT_W    = 2;

    localparam logic [REQ_W-1:0] REQ_WRITE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ENTER  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LEAVE  = 2'd2;

    localparam logic [OP_W-1:0] OP_STORE  = 2'd0;
    localparam logic [OP_W-1:0] OP_SCROLL = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_TILDE = 8'h7E;
    localparam logic [CHAR_W-1:0] CH_A_ACUTE_OUT = 8'hA0;
    localparam logic [CHAR_W-1:0] CH_E_ACUTE_OUT = 8'h82;

    localparam logic [ACC_W-1:0] CP_A_ACUTE = 11'h0E1;
    localparam logic [ACC_W-1:0] CP_E_ACUTE = 11'h0E9;

    localparam logic [ROW_W-1:0]  ROW_STATUS = ROW_W'(STATUS_ROW);
    localparam logic [ROW_W-1:0]  ROW_BOTTOM = ROW_W'(STATUS_ROW - 1);
    localparam logic [COL_W-1:0]  COL_LIMIT  = COL_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] STATUS_ADDR = ADDR_W'(STATUS_ROW * COLUMNS);

    localparam logic [COLOUR_W-1:0] STATUS_COLOUR_RST = 8'd1;

    typedef struct packed {
        logic [REQ_W-1:0]    req_type;
        logic [CHAR_W-1:0]   char_code;
        logic [COLOUR_W-1:0] char_colour;
        logic                utf8_on;
    } tccw_req_t;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [ADDR_W-1:0]   cell_addr;
        logic [CHAR_W-1:0]   cell_char;
        logic [COLOUR_W-1:0] cell_colour;
        logic                last;
    } tccw_result_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] saved_row;
        logic [COL_W-1:0] saved_col;
        logic             scroll_en;
        logic [ACC_W-1:0] accum;
    } tccw_state_t;

    localparam tccw_state_t STATE_RST = '{
        row: '0, col: '0, saved_row: '0, saved_col: '0, scroll_en: 1'b1, accum: '0
    };

endpackage

// ===== design/tccw_step.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tccw_step
// Cursor update for one request: next cursor state and up to two commands.
// ============================================================================
module tccw_step (
    input  tccw_pkg::tccw_state_t          state,
    input  tccw_pkg::tccw_req_t            req,
    input  logic [tccw_pkg::COLOUR_W-1:0]  status_colour,
    output tccw_pkg::tccw_state_t          state_next,
    output tccw_pkg::tccw_result_t         res0,
    output tccw_pkg::tccw_result_t         res1,
    output logic [tccw_pkg::CNT_W-1:0]     num_res
);
    import tccw_pkg::*;

    logic [ACC_W-1:0]  acc_in;
    logic [ACC_W-1:0]  acc_cont;
    logic [CHAR_W-1:0] ch;
    logic              print;
    logic              do_scroll;
    logic [ROW_W-1:0]  row_w;
    logic [COL_W-1:0]  col_w;
    logic [COL_W-1:0]  col_inc;
    logic [PROD_W-1:0] addr_full;
    tccw_result_t      store_res;
    tccw_result_t      scroll_res;

    always_comb
    begin
        state_next = state;
        res0       = '0;
        res1       = '0;
        num_res    = '0;
        print      = 1'b0;
        ch         = req.char_code;
        acc_in     = req.utf8_on ? state.accum : '0;
        acc_cont   = acc_in | {5'd0, req.char_code[5:0]};
        do_scroll  = state.scroll_en && (state.row >= ROW_STATUS);
        row_w      = do_scroll ? ROW_BOTTOM : state.row;
        col_w      = (state.col >= COL_LIMIT) ? '0 : state.col;
        col_inc    = col_w + 1'b1;
        addr_full  = PROD_W'(row_w) * PROD_W'(COLUMNS) + PROD_W'(col_w);

        store_res.op          = OP_STORE;
        store_res.cell_addr   = addr_full[ADDR_W-1:0];
        store_res.cell_char   = ch;
        store_res.cell_colour = req.char_colour;
        store_res.last        = 1'b1;
        scroll_res.op          = OP_SCROLL;
        scroll_res.cell_addr   = '0;
        scroll_res.cell_char   = CH_BLANK;
        scroll_res.cell_colour = '0;
        scroll_res.last        = 1'b0;

        unique case (req.req_type)
            REQ_ENTER:
            begin
                state_next.scroll_en = 1'b0;
                state_next.saved_row = state.row;
                state_next.saved_col = state.col;
                state_next.row       = ROW_STATUS;
                state_next.col       = '0;
                res0.op          = OP_CLEAR;
                res0.cell_addr   = STATUS_ADDR;
                res0.cell_char   = CH_BLANK;
                res0.cell_colour = status_colour;
                res0.last        = 1'b1;
                num_res          = 2'd1;
            end
            REQ_LEAVE:
            begin
                state_next.scroll_en = 1'b1;
                state_next.row       = state.saved_row;
                state_next.col       = state.saved_col;
            end
            REQ_WRITE:
            begin
                state_next.accum = acc_in;
                if (req.char_code == CH_CR || req.char_code == CH_LF)
                begin
                    if (state.col != '0)
                    begin
                        state_next.col = '0;
                        if (state.scroll_en && state.row < ROW_STATUS)
                            state_next.row = state.row + 1'b1;
                    end
                end
                else if (req.utf8_on && req.char_code[7])
                begin
                    if (req.char_code[7:5] == 3'b110)
                    begin
                        state_next.accum = {req.char_code[4:0], 6'd0};
                    end
                    else
                    begin
                        state_next.accum = '0;
                        print            = 1'b1;
                        if (req.char_code[7:6] == 2'b10 && acc_cont == CP_A_ACUTE)
                            ch = CH_A_ACUTE_OUT;
                        else if (req.char_code[7:6] == 2'b10 && acc_cont == CP_E_ACUTE)
                            ch = CH_E_ACUTE_OUT;
                        else
                            ch = CH_TILDE;
                    end
                end
                else
                begin
                    print = 1'b1;
                end

                if (print)
                begin
                    store_res.cell_char = ch;
                    if (col_inc >= COL_LIMIT)
                    begin
                        state_next.col = '0;
                        if (state.scroll_en && row_w < ROW_STATUS)
                            state_next.row = row_w + 1'b1;
                        else
                            state_next.row = row_w;
                    end
                    else
                    begin
                        state_next.col = col_inc;
                        state_next.row = row_w;
                    end
                    if (do_scroll)
                    begin
                        res0    = scroll_res;
                        res1    = store_res;
                        num_res = 2'd2;
                    end
                    else
                    begin
                        res0    = store_res;
                        num_res = 2'd1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== design/tccw_outq.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tccw_outq
// Two-slot result queue; takes up to two commands per cycle, shows one.
// ============================================================================
module tccw_outq (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  logic [tccw_pkg::CNT_W-1:0]     num_res,
    input  tccw_pkg::tccw_result_t         res0,
    input  tccw_pkg::tccw_result_t         res1,
    input  logic                           out_stall,
    output logic                           out_valid,
    output tccw_pkg::tccw_result_t         head,
    output logic [tccw_pkg::CNT_W-1:0]     room
);
    import tccw_pkg::*;

    tccw_result_t       slot0_reg, slot0_next;
    tccw_result_t       slot1_reg, slot1_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   cnt_pop;
    logic               pop;

    assign out_valid = (cnt_reg != '0);
    assign head      = slot0_reg;
    assign pop       = out_valid && !out_stall;
    assign cnt_pop   = cnt_reg - CNT_W'(pop);
    assign room      = 2'd2 - cnt_pop;

    always_comb
    begin
        slot0_next = pop ? slot1_reg : slot0_reg;
        slot1_next = slot1_reg;
        cnt_next   = cnt_pop;
        if (push && num_res != '0)
        begin
            cnt_next = cnt_pop + num_res;
            if (cnt_pop == '0)
            begin
                slot0_next = res0;
                slot1_next = res1;
            end
            else
            begin
                slot1_next = res0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

// ===== design/text_console_cursor_writer_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// text_console_cursor_writer_unit
// Cursor writer for an 80-column text screen: turns print and status-line
// requests into cell-store, scroll and clear commands.
// ============================================================================
//  channel | signals                                      | dir
//  --------+----------------------------------------------+-----
//  in      | in_valid, in_stall, req_type, char_code,     | in
//          | char_colour, utf8_on                         |
//  out     | out_valid, out_stall, op, cell_addr,         | out
//          | cell_char, cell_colour, last                 |
//  cfg     | cfg_valid, cfg_ready, cfg_data               | in
//
//  One request word per cycle while in_stall is low; a request is registered,
//  and its result words then pass through the result queue registers. A print
//  that scrolls gives two words; the result queue port shows one word at a time.
//  Async reset clears cursor, saved cursor, accumulator; scrolling on,
//  status colour 1. No clearing pass.
//  out_stall backs up into in_stall once the queue cannot take the next word.
// ============================================================================
module text_console_cursor_writer_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [tccw_pkg::REQ_W-1:0]      req_type,
    input  logic [tccw_pkg::CHAR_W-1:0]     char_code,
    input  logic [tccw_pkg::COLOUR_W-1:0]   char_colour,
    input  logic                            utf8_on,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [tccw_pkg::OP_W-1:0]       op,
    output logic [tccw_pkg::ADDR_W-1:0]     cell_addr,
    output logic [tccw_pkg::CHAR_W-1:0]     cell_char,
    output logic [tccw_pkg::COLOUR_W-1:0]   cell_colour,
    output logic                            last,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tccw_pkg::COLOUR_W-1:0]   cfg_data
);
    import tccw_pkg::*;

    logic                  req_vld_reg, req_vld_next;
    tccw_req_t             req_reg;
    tccw_state_t           state_reg, state_next;
    logic [COLOUR_W-1:0]   status_colour_reg;
    tccw_result_t          res0, res1, head;
    logic [CNT_W-1:0]      num_res, room;
    logic                  advance, accept;

    assign cfg_ready = 1'b1;
    assign advance   = req_vld_reg && (num_res <= room);
    assign in_stall  = req_vld_reg && !advance;
    assign accept    = in_valid && !in_stall;
    assign req_vld_next = accept || (req_vld_reg && !advance);

    tccw_step u_step (
        .state         (state_reg),
        .req           (req_reg),
        .status_colour (status_colour_reg),
        .state_next    (state_next),
        .res0          (res0),
        .res1          (res1),
        .num_res       (num_res)
    );

    tccw_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (advance),
        .num_res   (num_res),
        .res0      (res0),
        .res1      (res1),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .head      (head),
        .room      (room)
    );

    assign op          = head.op;
    assign cell_addr   = head.cell_addr;
    assign cell_char   = head.cell_char;
    assign cell_colour = head.cell_colour;
    assign last        = head.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_vld_reg       <= 1'b0;
            state_reg         <= STATE_RST;
            status_colour_reg <= STATUS_COLOUR_RST;
        end
        else
        begin
            req_vld_reg <= req_vld_next;
            if (advance)
                state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                status_colour_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg.req_type    <= req_type;
            req_reg.char_code   <= char_code;
            req_reg.char_colour <= char_colour;
            req_reg.utf8_on     <= utf8_on;
        end
    end

endmodule

// ===== design/tccw_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tccw_checker
// Port-level checks of the cursor writer, bound to the top level.
// ============================================================================
module tccw_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [tccw_pkg::OP_W-1:0]       op,
    input  logic [tccw_pkg::ADDR_W-1:0]     cell_addr,
    input  logic [tccw_pkg::CHAR_W-1:0]     cell_char,
    input  logic [tccw_pkg::COLOUR_W-1:0]   cell_colour,
    input  logic                            last
);
    import tccw_pkg::*;

    localparam logic [ADDR_W-1:0] MAX_ADDR = ADDR_W'(STATUS_ROW * COLUMNS + COLUMNS - 1);

    a_scroll_then_store: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && op == OP_SCROLL |=> out_valid && op == OP_STORE && last)
        else $error("scroll word not followed by its store word");

    a_scroll_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && op == OP_SCROLL |-> !last && cell_char == CH_BLANK)
        else $error("scroll word malformed");

    a_clear_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && op == OP_CLEAR |-> last && cell_addr == STATUS_ADDR)
        else $error("clear word malformed");

    a_store_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && op == OP_STORE |-> cell_addr <= MAX_ADDR)
        else $error("store address off screen");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(op) && $stable(cell_addr)
            && $stable(cell_char) && $stable(cell_colour) && $stable(last))
        else $error("stalled output word changed");

endmodule

bind text_console_cursor_writer_unit tccw_checker u_tccw_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .op          (op),
    .cell_addr   (cell_addr),
    .cell_char   (cell_char),
    .cell_colour (cell_colour),
    .last        (last)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for text_console_cursor_writer_unit. A queue of print
// and status-line requests is filled per phase and fed to the block by a
// clocked driver. A predictor of the cursor, saved cursor, scroll flag and
// UTF-8 accumulator turns each accepted request into the expected command
// words, and a monitor compares every output word field by field. Both sides
// idle at random, and the status colour is rewritten between phases.
// ============================================================================
module tb_top;

    import tccw_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [REQ_W-1:0]    req_type = REQ_WRITE;
    logic [CHAR_W-1:0]   char_code = '0;
    logic [COLOUR_W-1:0] char_colour = '0;
    logic                utf8_on = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [OP_W-1:0]     op;
    logic [ADDR_W-1:0]   cell_addr;
    logic [CHAR_W-1:0]   cell_char;
    logic [COLOUR_W-1:0] cell_colour;
    logic                last;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [COLOUR_W-1:0] cfg_data = '0;

    tccw_req_t    request_queue[$];
    tccw_result_t expected_cmds[$];

    logic [ROW_W-1:0]    cur_row = '0;
    logic [COL_W-1:0]    cur_col = '0;
    logic [ROW_W-1:0]    save_row = '0;
    logic [COL_W-1:0]    save_col = '0;
    logic                scroll_on = 1'b1;
    logic [ACC_W-1:0]    utf8_acc = '0;
    logic [COLOUR_W-1:0] fill_colour = STATUS_COLOUR_RST;

    int  in_idle_pct = 32;
    int  out_stall_pct = 68;
    int  error_count = 0;
    int  quiet_cycles = 0;
    int  phase_items = 0;
    bit  in_taken = 1'b0;

    text_console_cursor_writer_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .char_code   (char_code),
        .char_colour (char_colour),
        .utf8_on     (utf8_on),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .op          (op),
        .cell_addr   (cell_addr),
        .cell_char   (cell_char),
        .cell_colour (cell_colour),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always #10 clk = ~clk;

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        error_count++;
        $display("%0t ns: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    endtask

    function automatic void expect_cmd(logic [OP_W-1:0] kind, logic [ADDR_W-1:0] addr,
                                       logic [CHAR_W-1:0] ch, logic [COLOUR_W-1:0] colour,
                                       logic fin);
        tccw_result_t cmd;
        cmd.op          = kind;
        cmd.cell_addr   = addr;
        cmd.cell_char   = ch;
        cmd.cell_colour = colour;
        cmd.last        = fin;
        expected_cmds.push_back(cmd);
    endfunction

    function automatic void advance_row();
        if (scroll_on && cur_row < ROW_STATUS)
            cur_row = cur_row + 1'b1;
    endfunction

    // cursor and command model for one accepted request word
    function automatic void predict_screen_cmds(tccw_req_t rq);
        logic [CHAR_W-1:0] ch;
        ch = rq.char_code;
        if (rq.req_type == REQ_ENTER)
        begin
            scroll_on = 1'b0;
            save_row  = cur_row;
            save_col  = cur_col;
            cur_row   = ROW_STATUS;
            cur_col   = '0;
            expect_cmd(OP_CLEAR, STATUS_ADDR, CH_BLANK, fill_colour, 1'b1);
            return;
        end
        if (rq.req_type == REQ_LEAVE)
        begin
            scroll_on = 1'b1;
            cur_row   = save_row;
            cur_col   = save_col;
            return;
        end
        if (rq.req_type != REQ_WRITE)
            return;

        if (!rq.utf8_on)
            utf8_acc = '0;
        if (ch == CH_CR || ch == CH_LF)
        begin
            if (cur_col != '0)
            begin
                advance_row();
                cur_col = '0;
            end
            return;
        end
        if (rq.utf8_on && ch[7])
        begin
            if (ch[7:5] == 3'b110)
            begin
                utf8_acc = {ch[4:0], 6'b0};
                return;
            end
            if (ch[7:6] == 2'b10)
            begin
                utf8_acc = utf8_acc | ACC_W'(ch[5:0]);
                if (utf8_acc == CP_A_ACUTE)
                    ch = CH_A_ACUTE_OUT;
                else if (utf8_acc == CP_E_ACUTE)
                    ch = CH_E_ACUTE_OUT;
                else
                    ch = CH_TILDE;
            end
            else
                ch = CH_TILDE;
            utf8_acc = '0;
        end
        if (scroll_on && cur_row >= ROW_STATUS)
        begin
            cur_row = ROW_BOTTOM;
            expect_cmd(OP_SCROLL, '0, CH_BLANK, '0, 1'b0);
        end
        if (cur_col >= COL_LIMIT)
            cur_col = '0;
        expect_cmd(OP_STORE, ADDR_W'(int'(cur_row) * COLUMNS + int'(cur_col)), ch,
                   rq.char_colour, 1'b1);
        cur_col = cur_col + 1'b1;
        if (cur_col >= COL_LIMIT)
        begin
            cur_col = '0;
            advance_row();
        end
    endfunction

    // driver: holds a word until it is taken
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (request_queue.size() != 0 && $urandom_range(0, 99) >= in_idle_pct)
            begin
                in_valid <= 1'b1;
                {req_type, char_code, char_colour, utf8_on} <= request_queue[0];
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(0, 99) < out_stall_pct);
    end

    // monitor: prediction on accept, check on output word, watchdog
    always @(posedge clk)
    begin
        tccw_result_t want;
        tccw_req_t    rq;
        bit           busy;
        if (rst_n)
        begin
            busy = 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                fill_colour = cfg_data;
                busy = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                busy = 1'b1;
                if (expected_cmds.size() == 0)
                    report_mismatch("unexpected word, op", 32'(op), 0);
                else
                begin
                    want = expected_cmds.pop_front();
                    if (op !== want.op)
                        report_mismatch("op", 32'(op), 32'(want.op));
                    if (cell_addr !== want.cell_addr)
                        report_mismatch("cell_addr", 32'(cell_addr), 32'(want.cell_addr));
                    if (cell_char !== want.cell_char)
                        report_mismatch("cell_char", 32'(cell_char), 32'(want.cell_char));
                    if (cell_colour !== want.cell_colour)
                        report_mismatch("cell_colour", 32'(cell_colour),
                                        32'(want.cell_colour));
                    if (last !== want.last)
                        report_mismatch("last", 32'(last), 32'(want.last));
                end
            end
            in_taken = in_valid && !in_stall;
            if (in_taken)
            begin
                busy = 1'b1;
                rq = request_queue.pop_front();
                predict_screen_cmds(rq);
            end
            quiet_cycles = busy ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("text_console_cursor_writer_unit verification failed");
                $finish;
            end
        end
    end

    task automatic push_req(logic [REQ_W-1:0] kind, logic [CHAR_W-1:0] code,
                            logic [COLOUR_W-1:0] colour, logic u8);
        tccw_req_t rq;
        rq.req_type    = kind;
        rq.char_code   = code;
        rq.char_colour = colour;
        rq.utf8_on     = u8;
        request_queue.push_back(rq);
        if (kind != REQ_UNUSED)
            phase_items++;
    endtask

    function automatic logic [CHAR_W-1:0] text_byte();
        if ($urandom_range(0, 4) == 0)
            return CHAR_W'($urandom_range(0, 255));
        return CHAR_W'($urandom_range(8'h20, 8'h7E));
    endfunction

    function automatic logic [COLOUR_W-1:0] rand_colour();
        return COLOUR_W'($urandom_range(0, 255));
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic push_text(int count);
        repeat (count)
            push_req(REQ_WRITE, text_byte(), rand_colour(), rand_bit());
    endtask

    task automatic push_break();
        push_req(REQ_WRITE, $urandom_range(0, 1) ? CH_CR : CH_LF, rand_colour(), rand_bit());
    endtask

    task automatic add_random_burst();
        int kind;
        logic [CHAR_W-1:0] lead;
        logic [CHAR_W-1:0] cont;
        kind = $urandom_range(0, 99);
        if (kind < 35)
        begin
            push_text($urandom_range(1, 12));
            push_break();
            if ($urandom_range(0, 3) == 0)
                push_break();
        end
        else if (kind < 50)
        begin
            lead = ($urandom_range(0, 2) == 0) ? (8'hC0 | CHAR_W'($urandom_range(0, 31)))
                                               : 8'hC3;
            case ($urandom_range(0, 3))
                0: cont = 8'hA1;
                1: cont = 8'hA9;
                default: cont = 8'h80 | CHAR_W'($urandom_range(0, 63));
            endcase
            push_req(REQ_WRITE, lead, rand_colour(), 1'b1);
            case ($urandom_range(0, 5))
                0: push_req(REQ_WRITE, CH_LF, rand_colour(), 1'b1);
                1: push_req(REQ_WRITE, text_byte(), rand_colour(), 1'b0);
                default: ;
            endcase
            push_req(REQ_WRITE, cont, rand_colour(), 1'b1);
        end
        else if (kind < 60)
        begin
            push_req(REQ_ENTER, CHAR_W'($urandom_range(0, 255)), rand_colour(), rand_bit());
            if ($urandom_range(0, 3) == 0)
                push_req(REQ_ENTER, CHAR_W'($urandom_range(0, 255)), rand_colour(),
                         rand_bit());
            if ($urandom_range(0, 4) == 0)
                push_text($urandom_range(78, 90));
            else
                push_text($urandom_range(0, 6));
            if ($urandom_range(0, 2) == 0)
                push_break();
            push_req(REQ_LEAVE, CHAR_W'($urandom_range(0, 255)), rand_colour(), rand_bit());
        end
        else if (kind < 63)
            push_text($urandom_range(78, 85));
        else if (kind < 75)
            push_req(REQ_W'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                     rand_colour(), rand_bit());
        else if (kind < 82)
            push_req($urandom_range(0, 1) ? REQ_ENTER : REQ_LEAVE,
                     CHAR_W'($urandom_range(0, 255)), rand_colour(), rand_bit());
        else
            repeat ($urandom_range(4, 20))
            begin
                push_text($urandom_range(1, 2));
                push_break();
            end
    endtask

    task automatic wait_drained();
        while (request_queue.size() != 0 || expected_cmds.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_status_colour(logic [COLOUR_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random_phase(int target, int in_pct, int out_pct);
        in_idle_pct   = in_pct;
        out_stall_pct = out_pct;
        phase_items   = 0;
        while (phase_items < target)
            add_random_burst();
        wait_drained();
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        push_req(REQ_WRITE, 8'h41, 8'h00, 1'b0);
        push_req(REQ_WRITE, 8'hFF, 8'hFF, 1'b0);
        push_req(REQ_WRITE, CH_LF, 8'h00, 1'b0);
        push_req(REQ_WRITE, CH_CR, 8'hFF, 1'b0);     // column zero: no move
        push_req(REQ_WRITE, 8'hC3, 8'h11, 1'b1);
        push_req(REQ_WRITE, CH_LF, 8'h22, 1'b1);     // accumulator survives
        push_req(REQ_WRITE, 8'hA1, 8'h33, 1'b1);
        push_req(REQ_WRITE, 8'hC3, 8'h44, 1'b1);
        push_req(REQ_WRITE, 8'hA9, 8'h55, 1'b1);
        push_req(REQ_WRITE, 8'hC2, 8'h66, 1'b1);
        push_req(REQ_WRITE, 8'hBF, 8'h77, 1'b1);
        push_req(REQ_WRITE, 8'hC3, 8'h88, 1'b1);
        push_req(REQ_WRITE, 8'h41, 8'h99, 1'b0);     // raw byte clears accumulator
        push_req(REQ_WRITE, 8'hA1, 8'hAA, 1'b1);
        push_req(REQ_WRITE, 8'hE5, 8'hBB, 1'b1);
        push_req(REQ_WRITE, 8'h80, 8'hCC, 1'b1);
        push_req(REQ_UNUSED, 8'hAA, 8'h55, 1'b1);
        push_req(REQ_ENTER, 8'h00, 8'h00, 1'b0);
        push_req(REQ_WRITE, 8'h53, 8'h5A, 1'b0);
        push_req(REQ_ENTER, 8'hFF, 8'hFF, 1'b1);     // re-entry saves status cursor
        push_req(REQ_LEAVE, 8'h00, 8'h00, 1'b0);
        push_req(REQ_WRITE, 8'h78, 8'hA5, 1'b0);     // scroll from status row
        push_req(REQ_LEAVE, 8'hFF, 8'hFF, 1'b1);     // leave while not in status
        push_req(REQ_WRITE, CH_LF, 8'h00, 1'b0);
        push_req(REQ_WRITE, 8'h00, 8'h00, 1'b0);
        wait_drained();

        write_status_colour(8'h00);
        run_random_phase(125, 32, 68);
        write_status_colour(8'hFF);
        run_random_phase(125, 68, 32);
        write_status_colour(COLOUR_W'($urandom_range(1, 254)));
        run_random_phase(125, 0, 0);

        repeat (10) @(negedge clk);
        if (error_count == 0 && expected_cmds.size() == 0)
            $display("text_console_cursor_writer_unit verification clean");
        else
            $display("text_console_cursor_writer_unit verification failed");
        $finish;
    end

endmodule
